// ===== design/wst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wst_pkg
// shared types and constants for the wait statistics window block
// ----------------------------------------------------------------------------
package wst_pkg;

  localparam int unsigned DefSlots = 8;

  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] Max16 = 16'hFFFF;
  localparam logic [19:0] Max20 = 20'hF_FFFF;
  localparam logic [31:0] NoCmd = 32'hFFFF_FFFF;

  localparam logic [2:0] KindRaw   = 3'd0;
  localparam logic [2:0] KindSpace = 3'd1;
  localparam logic [2:0] KindSeqno = 3'd2;

  localparam logic [1:0] RegEnable    = 2'd0;
  localparam logic [1:0] RegReport    = 2'd1;
  localparam logic [1:0] RegWinLength = 2'd2;
  localparam logic [1:0] RegMaxEvents = 2'd3;

  typedef enum logic [3:0] {
    StIdle,
    StScan,
    StUpdate,
    StCheck,
    StDiv,
    StRank,
    StEmit,
    StClear
  } state_e;

  typedef struct packed {
    logic in_ack;
    logic start_scan;
    logic scan_step;
    logic apply;
    logic start_div;
    logic div_step;
    logic start_rank;
    logic rank_step;
    logic clear;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic rank_done;
    logic close;
  } stat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] elapsed_wait;
    logic        timed_out;
    logic [31:0] cmd_type;
    logic [47:0] now_time;
  } in_word_t;

  typedef struct packed {
    logic        item_type;
    logic        last;
    logic [47:0] window_span;
    logic [47:0] wait_sum;
    logic [19:0] wait_ratio;
    logic [15:0] event_count;
    logic [15:0] raw_count;
    logic [15:0] space_count;
    logic [15:0] seqno_count;
    logic [15:0] timeout_total;
    logic [31:0] peak_wait;
    logic [31:0] top_cmd_type;
  } out_word_t;

  function automatic logic [15:0] inc16(input logic [15:0] v);
    return (v == Max16) ? v : v + 16'd1;
  endfunction

  function automatic logic [47:0] add48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? Max48 : s[47:0];
  endfunction

endpackage

// ===== design/wst_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wst_in_if / wst_out_if
// valid/ready channels carrying event and result words
// ----------------------------------------------------------------------------
interface wst_in_if;
  logic               valid;
  logic               ready;
  wst_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wst_out_if;
  logic               valid;
  logic               ready;
  wst_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/wst_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wst_ctrl
// sequencer for event update, window close, ranking and emission
// ----------------------------------------------------------------------------
module wst_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            enable_i,
  input  logic            report_i,
  input  logic            out_ready_i,
  input  wst_pkg::stat_t  stat_i,
  output wst_pkg::ctrl_t  ctrl_o,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output logic            out_last_o
);
  import wst_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] emit_q, emit_d;
  logic       ov_q, ov_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_valid_i) state_d = enable_i ? StScan : StIdle;
      StScan:   if (stat_i.scan_done) state_d = StUpdate;
      StUpdate: state_d = StCheck;
      StCheck: begin
        if (!stat_i.close) state_d = StIdle;
        else if (report_i) state_d = StDiv;
        else state_d = StClear;
      end
      StDiv:  if (stat_i.div_done) state_d = StRank;
      StRank: if (stat_i.rank_done) state_d = StEmit;
      StEmit: if (ov_q && out_ready_i && emit_q == 2'd3) state_d = StClear;
      StClear: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    emit_d = emit_q;
    ov_d   = ov_q;
    unique case (state_q)
      StIdle: begin
        ctrl_o.in_ack     = in_valid_i;
        ctrl_o.start_scan = in_valid_i && enable_i;
      end
      StScan:   ctrl_o.scan_step = 1'b1;
      StUpdate: ctrl_o.apply = 1'b1;
      StCheck:  ctrl_o.start_div = stat_i.close && report_i;
      StDiv: begin
        ctrl_o.div_step   = 1'b1;
        ctrl_o.start_rank = stat_i.div_done;
      end
      StRank: begin
        ctrl_o.rank_step = 1'b1;
        if (stat_i.rank_done) begin
          ctrl_o.out_load = 1'b1;
          emit_d = 2'd0;
          ov_d   = 1'b1;
        end
      end
      StEmit: begin
        if (ov_q && out_ready_i) begin
          if (emit_q == 2'd3) begin
            ov_d = 1'b0;
          end else begin
            emit_d = emit_q + 2'd1;
            ctrl_o.out_load = 1'b1;
          end
        end
      end
      StClear: ctrl_o.clear = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      emit_q  <= 2'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
      ov_q    <= ov_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ov_q;
  assign out_last_o  = (emit_q == 2'd3);
endmodule

// ===== design/wst_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wst_dpath
// window totals, command table scan, permille divider and ranking
// ----------------------------------------------------------------------------
module wst_dpath #(
  parameter int unsigned SLOTS = wst_pkg::DefSlots
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wst_pkg::ctrl_t     ctrl_i,
  input  wst_pkg::in_word_t  in_i,
  input  logic [31:0]        win_len_i,
  input  logic [15:0]        max_ev_i,
  input  logic               out_last_i,
  output wst_pkg::stat_t     stat_o,
  output wst_pkg::out_word_t out_o
);
  import wst_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS + 1);
  localparam int unsigned IW = $clog2(SLOTS);

  logic [47:0] start_q;
  logic [15:0] events_q;
  logic [47:0] twait_q;
  logic [31:0] mwait_q;
  logic [15:0] tmo_q;
  logic [15:0] kcnt_q [3];
  logic [31:0] scmd_q [SLOTS];
  logic [15:0] scnt_q [SLOTS];
  logic [47:0] swait_q [SLOTS];

  in_word_t    ev_q;
  logic [47:0] span_q;

  // table scan
  logic [SW-1:0] idx_q;
  logic          hit_v_q, emp_v_q;
  logic [IW-1:0] hit_q, emp_q, least_q;
  logic [IW-1:0] idx_s;
  logic [IW-1:0] pick_s;
  logic          is_cmd;

  assign idx_s  = idx_q[IW-1:0];
  assign is_cmd = (ev_q.kind == KindSeqno) && (ev_q.cmd_type != NoCmd);
  assign pick_s = hit_v_q ? hit_q : (emp_v_q ? emp_q : least_q);

  // divider
  logic [57:0] rem_q, quo_q;
  logic [5:0]  dcnt_q;
  logic [58:0] rem_sh;
  assign rem_sh = {rem_q, quo_q[57]};

  // ranking
  logic [IW-1:0] top_q [3];
  logic          topv_q [3];
  logic [SW-1:0] ridx_q;
  logic [IW-1:0] ridx_s;
  assign ridx_s = ridx_q[IW-1:0];

  logic [47:0] span_now;
  assign span_now = in_i.now_time - ((start_q == '0) ? in_i.now_time : start_q);

  logic [15:0] ev_next;
  assign ev_next = inc16(events_q);
  logic [1:0] rank_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      events_q <= '0;
      twait_q  <= '0;
      mwait_q  <= '0;
      tmo_q    <= '0;
      for (int k = 0; k < 3; k++) kcnt_q[k] <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        scmd_q[s]  <= '0;
        scnt_q[s]  <= '0;
        swait_q[s] <= '0;
      end
    end else if (ctrl_i.clear) begin
      start_q  <= '0;
      events_q <= '0;
      twait_q  <= '0;
      mwait_q  <= '0;
      tmo_q    <= '0;
      for (int k = 0; k < 3; k++) kcnt_q[k] <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        scmd_q[s]  <= '0;
        scnt_q[s]  <= '0;
        swait_q[s] <= '0;
      end
    end else if (ctrl_i.start_scan) begin
      if (start_q == '0) start_q <= in_i.now_time;
      events_q <= ev_next;
      twait_q  <= add48(twait_q, in_i.elapsed_wait);
      if (in_i.elapsed_wait > mwait_q) mwait_q <= in_i.elapsed_wait;
      if (in_i.timed_out) tmo_q <= inc16(tmo_q);
      if (in_i.kind < 3'd3) kcnt_q[in_i.kind[1:0]] <= inc16(kcnt_q[in_i.kind[1:0]]);
    end else if (ctrl_i.apply && is_cmd) begin
      // an occupied matching slot accumulates, any other chosen slot restarts
      if (hit_v_q && scnt_q[hit_q] != '0) begin
        scnt_q[hit_q]  <= inc16(scnt_q[hit_q]);
        swait_q[hit_q] <= add48(swait_q[hit_q], ev_q.elapsed_wait);
      end else begin
        scmd_q[pick_s]  <= ev_q.cmd_type;
        scnt_q[pick_s]  <= 16'd1;
        swait_q[pick_s] <= {16'd0, ev_q.elapsed_wait};
      end
    end
  end

  // slot scan: first match, else first empty, else first least count
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start_scan) begin
      ev_q    <= in_i;
      span_q  <= span_now;
      idx_q   <= '0;
      hit_v_q <= 1'b0;
      emp_v_q <= 1'b0;
      least_q <= '0;
    end else if (ctrl_i.scan_step && idx_q != SW'(SLOTS)) begin
      if (!hit_v_q) begin
        if (scmd_q[idx_s] == ev_q.cmd_type) begin
          hit_v_q <= 1'b1;
          hit_q   <= idx_s;
        end else begin
          if (scnt_q[idx_s] == '0 && !emp_v_q) begin
            emp_v_q <= 1'b1;
            emp_q   <= idx_s;
          end
          if (scnt_q[idx_s] < scnt_q[least_q]) least_q <= idx_s;
        end
      end
      idx_q <= idx_q + SW'(1);
    end
  end
  assign stat_o.scan_done = (idx_q == SW'(SLOTS));

  assign stat_o.close = (span_q < {16'd0, win_len_i}) && (events_q < max_ev_i) ? 1'b0 : 1'b1;

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start_div) begin
      quo_q  <= {twait_q, 10'd0} - {5'd0, twait_q, 5'd0} + {7'd0, twait_q, 3'd0};
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (ctrl_i.div_step && dcnt_q != 6'd58) begin
      if (rem_sh >= {11'd0, span_q}) rem_q <= 58'(rem_sh - {11'd0, span_q});
      else rem_q <= rem_sh[57:0];
      quo_q  <= {quo_q[56:0], rem_sh >= {11'd0, span_q}};
      dcnt_q <= dcnt_q + 6'd1;
    end
  end
  assign stat_o.div_done = (dcnt_q == 6'd58);

  // insertion ranking over slots, one slot per cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start_rank) begin
      ridx_q <= '0;
      for (int r = 0; r < 3; r++) topv_q[r] <= 1'b0;
    end else if (ctrl_i.rank_step && ridx_q != SW'(SLOTS)) begin
      if (scnt_q[ridx_s] != '0) begin
        if (!topv_q[0] || swait_q[top_q[0]] < swait_q[ridx_s]) begin
          top_q[2] <= top_q[1]; topv_q[2] <= topv_q[1];
          top_q[1] <= top_q[0]; topv_q[1] <= topv_q[0];
          top_q[0] <= ridx_s;   topv_q[0] <= 1'b1;
        end else if (!topv_q[1] || swait_q[top_q[1]] < swait_q[ridx_s]) begin
          top_q[2] <= top_q[1]; topv_q[2] <= topv_q[1];
          top_q[1] <= ridx_s;   topv_q[1] <= 1'b1;
        end else if (!topv_q[2] || swait_q[top_q[2]] < swait_q[ridx_s]) begin
          top_q[2] <= ridx_s;   topv_q[2] <= 1'b1;
        end
      end
      ridx_q <= ridx_q + SW'(1);
    end
  end
  assign stat_o.rank_done = (ridx_q == SW'(SLOTS));

  // output register and emission counter
  logic [1:0] oc_q;
  out_word_t  o_d;
  always_comb begin
    rank_sel = oc_q - 2'd1;
    o_d = '0;
    o_d.window_span = span_q;
    if (oc_q == 2'd0) begin
      o_d.wait_sum      = twait_q;
      o_d.wait_ratio    = (span_q == '0) ? '0 :
                          (quo_q[57:20] != '0) ? Max20 : quo_q[19:0];
      o_d.event_count   = events_q;
      o_d.raw_count     = kcnt_q[KindRaw[1:0]];
      o_d.space_count   = kcnt_q[KindSpace[1:0]];
      o_d.seqno_count   = kcnt_q[KindSeqno[1:0]];
      o_d.timeout_total = tmo_q;
      o_d.peak_wait     = mwait_q;
      o_d.top_cmd_type  = NoCmd;
    end else begin
      o_d.item_type = 1'b1;
      o_d.last      = (oc_q == 2'd3);
      if (topv_q[rank_sel]) begin
        o_d.wait_sum     = swait_q[top_q[rank_sel]];
        o_d.event_count  = scnt_q[top_q[rank_sel]];
        o_d.top_cmd_type = scmd_q[top_q[rank_sel]];
      end else begin
        o_d.top_cmd_type = NoCmd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) oc_q <= '0;
    else if (ctrl_i.start_rank) oc_q <= '0;
    else if (ctrl_i.out_load) oc_q <= oc_q + 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) out_o <= o_d;
  end

  logic unused_last;
  assign unused_last = out_last_i;
endmodule

// ===== design/wait_stats_window_topk_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wait_stats_window_topk_table
// windowed wait event totals with a command table and top-3 report
// ----------------------------------------------------------------------------
// sequence: an enabled event passes the accept, scan, update and check states
// a window close adds, with report on, the divider, ranking and 4 output words,
// and always the clear state
// input: a new event is accepted only in idle, once the previous one is done
// reset: asynchronous, clears all totals and the table; registers to defaults
// ----------------------------------------------------------------------------
module wait_stats_window_topk_table #(
  parameter int unsigned SLOTS = wst_pkg::DefSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wst_in_if.sink      in_if,
  wst_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import wst_pkg::*;

  // configuration registers
  logic        enable_q, report_q;
  logic [31:0] winlen_q;
  logic [15:0] maxev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      report_q <= 1'b1;
      winlen_q <= 32'd1000000;
      maxev_q  <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegEnable:    enable_q <= cfg_data_i[0];
        RegReport:    report_q <= cfg_data_i[0];
        RegWinLength: winlen_q <= cfg_data_i;
        RegMaxEvents: maxev_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  ctrl_t ctrl;
  stat_t stat;
  logic  last;

  wst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .enable_i    (enable_q),
    .report_i    (report_q),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_last_o  (last)
  );

  wst_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .in_i       (in_if.data),
    .win_len_i  (winlen_q),
    .max_ev_i   (maxev_q),
    .out_last_i (last),
    .stat_o     (stat),
    .out_o      (out_if.data)
  );

`ifndef SYNTHESIS
  // no input word taken while results are pending
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready) else $error("input taken during report");
  // the last word is a command word
  a_last_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.data.last) |-> out_if.data.item_type)
    else $error("last flag on totals word");
  // totals word carries no command type
  a_totals_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.data.item_type) |-> out_if.data.top_cmd_type == NoCmd)
    else $error("totals word with command type");
`endif
endmodule
